### sv/first_fit_block_allocator_unit_assert.svh
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define FFBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("allocator assertion failed");

// consequence that must hold in the cycle after the trigger
`define FFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`else

`define FFBA_ASSERT(lbl, clk, rstn, prop)
`define FFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### sv/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

  // defaults for the top level parameters
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int ADDR_WIDTH_DEF   = 32;

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // configuration register reset values
  localparam logic [DATA_W-1:0] ARENA_BASE_RST  = 32'd0;
  localparam logic [DATA_W-1:0] ARENA_LIMIT_RST = 32'd65536;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARENA_BASE  = 1'b0,
    REG_ARENA_LIMIT = 1'b1
  } cfg_reg_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_SPACE   = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_t;

  // request broadcast to every cell during a scan
  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] addr;
  } req_t;

  // search token control passed from cell to cell
  typedef struct packed {
    logic vld;
    logic hit;
  } link_ctl_t;

endpackage

### sv/ffba_cell.sv
`timescale 1ns / 1ps

module ffba_cell #(
  parameter int ADDR_WIDTH = ffba_pkg::ADDR_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_range,
  input  ffba_pkg::req_t              req,
  input  ffba_pkg::link_ctl_t         lnk_in_ctl,
  input  logic [ADDR_WIDTH-1:0]       lnk_in_pay,
  input  logic                        wr_sel,
  input  logic [ADDR_WIDTH-1:0]       wr_pay,
  input  logic [ffba_pkg::DATA_W-1:0] wr_size,
  output ffba_pkg::link_ctl_t         lnk_out_ctl,
  output logic [ADDR_WIDTH-1:0]       lnk_out_pay
);

  // one table entry: payload address, recorded size, free flag
  logic [ADDR_WIDTH-1:0]       pay_r;
  logic [ffba_pkg::DATA_W-1:0] size_r;
  logic                        free_r;

  ffba_pkg::link_ctl_t   lnk_ctl_r;
  logic [ADDR_WIDTH-1:0] lnk_pay_r;

  logic [ADDR_WIDTH+ffba_pkg::DATA_W-1:0] pay_ext;
  logic                                   match;
  logic                                   take;

  // entry match against the broadcast request
  always_comb begin
    pay_ext = {{ffba_pkg::DATA_W{1'b0}}, pay_r};
    if (req.mode == ffba_pkg::MODE_ALLOC) begin
      match = free_r && (size_r >= req.size);
    end else begin
      match = (pay_ext[ffba_pkg::DATA_W-1:0] == req.addr);
    end
    take = lnk_in_ctl.vld && !lnk_in_ctl.hit && in_range && match;
  end

  // token stage towards the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnk_ctl_r <= '0;
    end else begin
      lnk_ctl_r.vld <= lnk_in_ctl.vld;
      lnk_ctl_r.hit <= lnk_in_ctl.hit || take;
    end
  end

  always_ff @(posedge clk) begin
    lnk_pay_r <= take ? pay_r : lnk_in_pay;
  end

  // entry update: append write or flag change on a hit
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      pay_r  <= wr_pay;
      size_r <= wr_size;
      free_r <= 1'b0;
    end else if (take) begin
      free_r <= (req.mode == ffba_pkg::MODE_FREE);
    end
  end

  assign lnk_out_ctl = lnk_ctl_r;
  assign lnk_out_pay = lnk_pay_r;

endmodule

### sv/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
// First-fit block allocator over a table of up to MAX_BLOCKS blocks.
// Requests enter on the command port: a transfer happens at a clock edge with
// start high and busy low. in_mode selects allocate (in_request_size) or
// free (in_free_address). Every request gives exactly one result, shown on
// out_payload_address and out_status for one cycle with out_valid high; the
// receiver has no way to hold it off.
// Allocate of size zero and free of the null address answer directly: the
// result strobe comes in the cycle after the transfer and busy stays low.
// Every other request runs a search token down the row of MAX_BLOCKS entry
// cells, one cell per cycle, in creation order; busy stays high until the
// result strobe, and the next request can be taken in that strobe cycle. A
// miss on allocate with room left appends a block at the arena break in the
// cycle the token leaves the row. The user must write configuration (cfg_we,
// cfg_index, cfg_data) only while busy is low; the block itself does not
// enforce it. Synchronous reset clears the block count, the break offset and
// the control path and sets arena_base to 0 and arena_limit to 65536; table
// entries hold no reset value and only entries below the block count are
// ever consulted.

`include "first_fit_block_allocator_unit_assert.svh"

module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_WIDTH   = ffba_pkg::ADDR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [ffba_pkg::DATA_W-1:0]    in_request_size,
  input  logic [ffba_pkg::DATA_W-1:0]    in_free_address,
  // result channel
  output logic                           out_valid,
  output logic [ffba_pkg::DATA_W-1:0]    out_payload_address,
  output logic [ffba_pkg::STATUS_W-1:0]  out_status,
  // configuration port
  input  logic                           cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffba_pkg::DATA_W-1:0]    cfg_data
);

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int BRK_W  = ffba_pkg::DATA_W + 1;
  localparam int NEED_W = ffba_pkg::DATA_W + 2;
  localparam int SUM_W  = (ADDR_WIDTH > NEED_W + 1) ? ADDR_WIDTH : NEED_W + 1;
  localparam int EXT_W  = ADDR_WIDTH + ffba_pkg::DATA_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                         state_r;
  logic                           out_valid_r;
  logic [ffba_pkg::DATA_W-1:0]    out_addr_r;
  ffba_pkg::status_t              out_status_r;
  logic [CNT_W-1:0]               count_r;
  logic [BRK_W-1:0]               brk_r;
  logic                           launch_r;
  ffba_pkg::req_t                 req_r;
  logic [NEED_W-1:0]              need_r;
  logic [ADDR_WIDTH-1:0]          newpay_r;
  logic [ffba_pkg::DATA_W-1:0]    base_r;
  logic [ffba_pkg::DATA_W-1:0]    limit_r;

  ffba_pkg::link_ctl_t            ctl_a [0:MAX_BLOCKS];
  logic [ADDR_WIDTH-1:0]          pay_a [0:MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0]          in_range;
  logic [MAX_BLOCKS-1:0]          wr_sel;
  logic [MAX_BLOCKS-1:0]          tok_vld;

  logic                           no_room;
  logic                           wr_en;
  logic [NEED_W-1:0]              need_nxt;
  logic [SUM_W-1:0]               pay_sum;
  logic [EXT_W-1:0]               tail_ext;
  logic [EXT_W-1:0]               newpay_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= ffba_pkg::ARENA_BASE_RST;
      limit_r <= ffba_pkg::ARENA_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (ffba_pkg::cfg_reg_t'(cfg_index))
        ffba_pkg::REG_ARENA_BASE:  base_r  <= cfg_data;
        ffba_pkg::REG_ARENA_LIMIT: limit_r <= cfg_data;
      endcase
    end
  end

  // arena arithmetic for a possible append, taken at the transfer
  always_comb begin
    need_nxt = NEED_W'(in_request_size) + NEED_W'(brk_r) + NEED_W'(HEADER_BYTES);
    pay_sum  = SUM_W'(base_r) + SUM_W'(brk_r) + SUM_W'(HEADER_BYTES);
  end

  // append decision when the token leaves the row
  always_comb begin
    no_room  = (count_r == CNT_W'(MAX_BLOCKS)) || (need_r > NEED_W'(limit_r));
    wr_en    = (state_r == S_SCAN) && ctl_a[MAX_BLOCKS].vld && !ctl_a[MAX_BLOCKS].hit
               && (req_r.mode == ffba_pkg::MODE_ALLOC) && !no_room;
    tail_ext   = {{ffba_pkg::DATA_W{1'b0}}, pay_a[MAX_BLOCKS]};
    newpay_ext = {{ffba_pkg::DATA_W{1'b0}}, newpay_r};
  end

  // token head
  assign ctl_a[0] = '{vld: launch_r, hit: 1'b0};
  assign pay_a[0] = '0;

  // row of entry cells
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    assign in_range[i] = (CNT_W'(i) < count_r);
    assign wr_sel[i]   = wr_en && (count_r[IDX_W-1:0] == IDX_W'(i));
    assign tok_vld[i]  = ctl_a[i+1].vld;

    ffba_cell #(
      .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .in_range    (in_range[i]),
      .req         (req_r),
      .lnk_in_ctl  (ctl_a[i]),
      .lnk_in_pay  (pay_a[i]),
      .wr_sel      (wr_sel[i]),
      .wr_pay      (newpay_r),
      .wr_size     (req_r.size),
      .lnk_out_ctl (ctl_a[i+1]),
      .lnk_out_pay (pay_a[i+1])
    );
  end

  // control state, table bookkeeping and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      brk_r       <= '0;
      launch_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r    <= '{mode: in_mode, size: in_request_size, addr: in_free_address};
            need_r   <= need_nxt;
            newpay_r <= pay_sum[ADDR_WIDTH-1:0];
            if ((in_mode == ffba_pkg::MODE_ALLOC) && (in_request_size == '0)) begin
              out_valid_r  <= 1'b1;
              launch_r     <= 1'b0;
              out_addr_r   <= '0;
              out_status_r <= ffba_pkg::STAT_ZERO;
            end else if ((in_mode == ffba_pkg::MODE_FREE) && (in_free_address == '0)) begin
              out_valid_r  <= 1'b1;
              launch_r     <= 1'b0;
              out_addr_r   <= '0;
              out_status_r <= ffba_pkg::STAT_OK;
            end else begin
              out_valid_r <= 1'b0;
              launch_r    <= 1'b1;
              state_r     <= S_SCAN;
            end
          end else begin
            out_valid_r <= 1'b0;
            launch_r    <= 1'b0;
          end
        end
        S_SCAN: begin
          launch_r    <= 1'b0;
          out_valid_r <= ctl_a[MAX_BLOCKS].vld;
          if (ctl_a[MAX_BLOCKS].vld) begin
            state_r <= S_IDLE;
            if (ctl_a[MAX_BLOCKS].hit) begin
              out_addr_r   <= (req_r.mode == ffba_pkg::MODE_ALLOC)
                              ? tail_ext[ffba_pkg::DATA_W-1:0] : '0;
              out_status_r <= ffba_pkg::STAT_OK;
            end else if (req_r.mode == ffba_pkg::MODE_FREE) begin
              out_addr_r   <= '0;
              out_status_r <= ffba_pkg::STAT_UNKNOWN;
            end else if (no_room) begin
              out_addr_r   <= '0;
              out_status_r <= ffba_pkg::STAT_SPACE;
            end else begin
              out_addr_r   <= newpay_ext[ffba_pkg::DATA_W-1:0];
              out_status_r <= ffba_pkg::STAT_OK;
              count_r      <= count_r + CNT_W'(1);
              brk_r        <= need_r[BRK_W-1:0];
            end
          end
        end
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;

  // checks on the control path
  `FFBA_ASSERT(a_result_when_idle, clk, rst_n, out_valid_r |-> (state_r == S_IDLE))
  `FFBA_ASSERT(a_tail_in_scan, clk, rst_n, ctl_a[MAX_BLOCKS].vld |-> (state_r == S_SCAN))
  `FFBA_ASSERT(a_single_token, clk, rst_n, $onehot0({tok_vld, launch_r}))
  `FFBA_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(MAX_BLOCKS))
  `FFBA_ASSERT_NEXT(a_transfer_progress, clk, rst_n, start && !busy, busy || out_valid_r)

endmodule
